[rtl/svc_pkg.sv]
package svc_pkg;

  localparam int unsigned FRAME_LENGTH = 2048;
  localparam int unsigned POS_W = (FRAME_LENGTH > 2) ? $clog2(FRAME_LENGTH) : 1;

  localparam logic [11:0] WIDTH_RESET  = 12'd640;
  localparam logic [11:0] HEIGHT_RESET = 12'd640;

  // One, two and three times the coordinate divisor 65534.
  localparam logic [17:0] COORD_DIV_X1 = 18'd65534;
  localparam logic [17:0] COORD_DIV_X2 = 18'd131068;
  localparam logic [17:0] COORD_DIV_X3 = 18'd196602;
  localparam logic [16:0] SAMPLE_OFFSET = 17'd32767;

  localparam logic [8:0] SCALE_ONE = 9'd256;
  localparam logic [7:0] RED_GAIN    = 8'd255;
  localparam logic [7:0] GREEN_BASE  = 8'd93;
  localparam logic [7:0] GREEN_GAIN  = 8'd162;
  localparam logic [7:0] BLUE_BASE   = 8'd239;
  localparam logic [7:0] BLUE_GAIN   = 8'd16;

  // Configuration register indexes.
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Operations of the shared multiplier.
  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_MX   = 4'd1;
  localparam logic [3:0] OP_MY   = 4'd2;
  localparam logic [3:0] OP_DX   = 4'd3;
  localparam logic [3:0] OP_DY   = 4'd4;
  localparam logic [3:0] OP_LIM  = 4'd5;
  localparam logic [3:0] OP_SQ   = 4'd6;
  localparam logic [3:0] OP_PL   = 4'd7;
  localparam logic [3:0] OP_PH   = 4'd8;

  typedef struct packed {
    logic       load;
    logic [3:0] op;
    logic       div_step;
    logic       cmp;
    logic [3:0] bit_idx;
    logic       out_load;
  } svc_cmd_t;

  typedef struct packed {
    logic first;
  } svc_sts_t;

endpackage

[rtl/svc_in_if.sv]
interface svc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;

  modport source (output valid, left_sample, right_sample, input ready);
  modport sink (input valid, left_sample, right_sample, output ready);
endinterface

[rtl/svc_out_if.sv]
interface svc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] point_x;
  logic [15:0] point_y;
  logic        line_valid;
  logic [15:0] line_start_x;
  logic [15:0] line_start_y;
  logic [7:0]  color_red;
  logic [7:0]  color_green;
  logic [7:0]  color_blue;

  modport source (output valid, point_x, point_y, line_valid, line_start_x, line_start_y,
                  color_red, color_green, color_blue, input ready);
  modport sink (input valid, point_x, point_y, line_valid, line_start_x, line_start_y,
                color_red, color_green, color_blue, output ready);
endinterface

[rtl/svc_ctrl.sv]
module svc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  svc_pkg::svc_sts_t  sts_i,
  output svc_pkg::svc_cmd_t  cmd_o
);
  import svc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MX   = 4'd1;
  localparam logic [3:0] S_MY   = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_DX   = 4'd4;
  localparam logic [3:0] S_DY   = 4'd5;
  localparam logic [3:0] S_LIM  = 4'd6;
  localparam logic [3:0] S_SQ   = 4'd7;
  localparam logic [3:0] S_PL   = 4'd8;
  localparam logic [3:0] S_PH   = 4'd9;
  localparam logic [3:0] S_CMP  = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  logic [3:0] state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.op    = OP_NONE;
    cmd_o.bit_idx = cnt_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MX;
        end
      end
      S_MX: begin
        cmd_o.op = OP_MX;
        state_d  = S_MY;
      end
      S_MY: begin
        cmd_o.op = OP_MY;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        state_d = sts_i.first ? S_DONE : S_DX;
      end
      S_DX: begin
        cmd_o.op = OP_DX;
        state_d  = S_DY;
      end
      S_DY: begin
        cmd_o.op = OP_DY;
        state_d  = S_LIM;
      end
      S_LIM: begin
        cmd_o.op = OP_LIM;
        cnt_d    = 4'd8;
        state_d  = S_SQ;
      end
      S_SQ: begin
        cmd_o.op = OP_SQ;
        state_d  = S_PL;
      end
      S_PL: begin
        cmd_o.op = OP_PL;
        state_d  = S_PH;
      end
      S_PH: begin
        cmd_o.op = OP_PH;
        state_d  = S_CMP;
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        if (cnt_q == 4'd0) begin
          state_d = S_DONE;
        end else begin
          cnt_d   = cnt_q - 4'd1;
          state_d = S_SQ;
        end
      end
      S_DONE: begin
        // The result register is free or being emptied in this cycle.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTH
  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == S_MX)
    else $error("accepted item did not start the multiply");
  a_out_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q)
    else $error("result load did not raise valid");
  a_search_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP && cnt_q == 4'd0) |=> state_q == S_DONE)
    else $error("scale search did not finish after its last bit");
  a_div_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MY) |=> (state_q == S_DIV))
    else $error("division did not follow the multiply");
`endif

endmodule

[rtl/svc_datapath.sv]
module svc_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  svc_pkg::svc_cmd_t  cmd_i,
  output svc_pkg::svc_sts_t  sts_o,
  input  logic [11:0]        width_i,
  input  logic [11:0]        height_i,
  input  logic signed [15:0] left_i,
  input  logic signed [15:0] right_i,
  output logic [15:0]        point_x_o,
  output logic [15:0]        point_y_o,
  output logic               line_valid_o,
  output logic [15:0]        line_start_x_o,
  output logic [15:0]        line_start_y_o,
  output logic [7:0]         color_red_o,
  output logic [7:0]         color_green_o,
  output logic [7:0]         color_blue_o
);
  import svc_pkg::*;

  logic [16:0] tx_q, ty_q;
  logic [31:0] dvx_q, dvy_q;
  logic [15:0] qx_q, qy_q;
  logic [33:0] d2_q;
  logic [35:0] lim2_q;
  logic [17:0] msq_q;
  logic [34:0] pl_q, ph_q;
  logic [8:0]  k_q;
  logic [15:0] px_q, py_q;
  logic [POS_W-1:0] pos_q;

  logic [17:0] mul_a, mul_b;
  logic [35:0] mul_p;
  logic [15:0] cur_x, cur_y, dx, dy;
  logic [8:0]  cand;
  logic [52:0] lhs;
  logic [8:0]  k_cap;
  logic [16:0] red_p, green_p;
  logic [12:0] blue_p;
  logic        first;

  // With n = q0 * 65536 + low, the remainder n - q0 * 65534 is low + 2 * q0,
  // which stays below four divisors, so at most three subtractions remain.
  function automatic logic [15:0] coord_quotient(input logic [31:0] n);
    logic [15:0] q0;
    logic [17:0] r0;
    logic [15:0] adj;
    q0 = n[31:16];
    r0 = {2'b00, n[15:0]} + {1'b0, q0, 1'b0};
    priority if (r0 >= COORD_DIV_X3) begin
      adj = 16'd3;
    end else if (r0 >= COORD_DIV_X2) begin
      adj = 16'd2;
    end else if (r0 >= COORD_DIV_X1) begin
      adj = 16'd1;
    end else begin
      adj = 16'd0;
    end
    return q0 + adj;
  endfunction

  assign cur_x = qx_q;
  assign cur_y = qy_q;
  assign dx    = (cur_x > px_q) ? (cur_x - px_q) : (px_q - cur_x);
  assign dy    = (cur_y > py_q) ? (cur_y - py_q) : (py_q - cur_y);
  assign cand  = k_q | (9'd1 << cmd_i.bit_idx);
  assign first = (pos_q == '0);
  assign sts_o.first = first;

  always_comb begin
    unique case (cmd_i.op)
      OP_MX:   begin mul_a = {1'b0, tx_q};  mul_b = {6'd0, width_i}; end
      OP_MY:   begin mul_a = {1'b0, ty_q};  mul_b = {6'd0, height_i}; end
      OP_DX:   begin mul_a = {2'd0, dx};    mul_b = {2'd0, dx}; end
      OP_DY:   begin mul_a = {2'd0, dy};    mul_b = {2'd0, dy}; end
      OP_LIM:  begin mul_a = {width_i, 6'd0}; mul_b = {width_i, 6'd0}; end
      OP_SQ:   begin mul_a = {9'd0, cand};  mul_b = {9'd0, cand}; end
      OP_PL:   begin mul_a = msq_q;         mul_b = {1'b0, d2_q[16:0]}; end
      OP_PH:   begin mul_a = msq_q;         mul_b = {1'b0, d2_q[33:17]}; end
      default: begin mul_a = '0;            mul_b = '0; end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign lhs   = {1'b0, ph_q, 17'd0} + {18'd0, pl_q};
  assign k_cap = (k_q > SCALE_ONE) ? SCALE_ONE : k_q;
  assign red_p   = k_cap * RED_GAIN;
  assign green_p = k_cap * GREEN_GAIN;
  assign blue_p  = k_cap * BLUE_GAIN[4:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tx_q <= (left_i == 16'sh8000) ? 17'd0
              : 17'({{1{left_i[15]}}, left_i} + SAMPLE_OFFSET);
      ty_q <= 17'(SAMPLE_OFFSET - {{1{right_i[15]}}, right_i});
      k_q  <= '0;
    end
    unique case (cmd_i.op)
      OP_MX:  dvx_q  <= {mul_p[27:0], 4'd0};
      OP_MY:  dvy_q  <= {mul_p[27:0], 4'd0};
      OP_DX:  d2_q   <= mul_p[33:0];
      OP_DY:  d2_q   <= d2_q + mul_p[33:0];
      OP_LIM: lim2_q <= mul_p;
      OP_SQ:  msq_q  <= mul_p[17:0];
      OP_PL:  pl_q   <= mul_p[34:0];
      OP_PH:  ph_q   <= mul_p[34:0];
      default: begin
      end
    endcase
    if (cmd_i.div_step) begin
      qx_q <= coord_quotient(dvx_q);
      qy_q <= coord_quotient(dvy_q);
    end
    if (cmd_i.cmp && (lhs <= {17'd0, lim2_q})) begin
      k_q <= cand;
    end
    if (cmd_i.out_load) begin
      point_x_o <= cur_x;
      point_y_o <= cur_y;
      if (first) begin
        line_valid_o   <= 1'b0;
        line_start_x_o <= '0;
        line_start_y_o <= '0;
        color_red_o    <= '0;
        color_green_o  <= '0;
        color_blue_o   <= '0;
      end else begin
        line_valid_o   <= !((cur_x == px_q) && (cur_y == py_q));
        line_start_x_o <= px_q;
        line_start_y_o <= py_q;
        color_red_o    <= red_p[15:8];
        color_green_o  <= GREEN_BASE + green_p[15:8];
        color_blue_o   <= BLUE_BASE + {3'd0, blue_p[12:8]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q  <= '0;
      py_q  <= '0;
      pos_q <= '0;
    end else if (cmd_i.out_load) begin
      px_q <= cur_x;
      py_q <= cur_y;
      if (pos_q == POS_W'(FRAME_LENGTH - 1)) begin
        pos_q <= '0;
      end else begin
        pos_q <= pos_q + 1'b1;
      end
    end
  end

endmodule

[rtl/stereo_xy_segment_colorizer_top.sv]
// Maps each stereo sample pair to a screen point (X from the left sample, Y from the
// negated right sample, unsigned with 4 fraction bits) and reports the segment from the
// previous point with a length-dependent color (none on the first sample of a frame). The
// result is loaded after the two coordinate multiplies and the constant divider on the
// first sample of a frame, and otherwise also after the 9-bit scale search, which steps
// through square, two partial products and compare per bit on the shared multiplier; the
// next item is accepted only in idle, and a result load waits while the output register
// is still full. A finished result waits in the output register while the next item is
// taken. Write screen_width at 0x0 and screen_height at 0x4 only while the block is idle.
module stereo_xy_segment_colorizer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  svc_in_if.sink      in_if,
  svc_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import svc_pkg::*;

  logic [11:0] width_q, height_q;
  svc_cmd_t    cmd;
  svc_sts_t    sts;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HEIGHT) ? {20'd0, height_q} : {20'd0, width_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_WIDTH) begin
        width_q <= pwdata[11:0];
      end else begin
        height_q <= pwdata[11:0];
      end
    end
  end

  svc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  svc_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .width_i        (width_q),
    .height_i       (height_q),
    .left_i         (in_if.left_sample),
    .right_i        (in_if.right_sample),
    .point_x_o      (out_if.point_x),
    .point_y_o      (out_if.point_y),
    .line_valid_o   (out_if.line_valid),
    .line_start_x_o (out_if.line_start_x),
    .line_start_y_o (out_if.line_start_y),
    .color_red_o    (out_if.color_red),
    .color_green_o  (out_if.color_green),
    .color_blue_o   (out_if.color_blue)
  );

endmodule

[sim/stereo_xy_segment_colorizer_top_tb.sv]
`timescale 1ns / 100ps
module stereo_xy_segment_colorizer_top_tb;
  import svc_pkg::*;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
  } sample_pair_t;

  typedef struct packed {
    logic [15:0] point_x;
    logic [15:0] point_y;
    logic        line_valid;
    logic [15:0] line_start_x;
    logic [15:0] line_start_y;
    logic [7:0]  color_red;
    logic [7:0]  color_green;
    logic [7:0]  color_blue;
  } segment_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  svc_in_if  in_if ();
  svc_out_if out_if ();

  stereo_xy_segment_colorizer_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if.sink),
    .out_if  (out_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  sample_pair_t pending_pairs[$];
  segment_t     expected_segments[$];
  int unsigned  error_count;
  bit           quiet_mode;
  bit           in_taken;
  int unsigned  send_gap;
  int unsigned  recv_stall;

  // Model state, updated as transfers are accepted on the input side.
  logic [11:0] model_width;
  logic [11:0] model_height;
  logic [15:0] model_prev_x;
  logic [15:0] model_prev_y;
  int unsigned model_frame_pos;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [15:0] scale_coord(input int signed s, input logic [11:0] size);
    longint signed t;
    longint unsigned p;
    t = s + 32767;
    if (t < 0) begin
      return 16'd0;
    end
    p = (longint'(t) * longint'(size) * 16) / 65534;
    return p[15:0];
  endfunction

  // Largest k in 0..256 with k*dist <= 64*width, squared to stay exact.
  function automatic int unsigned segment_scale(input logic [15:0] ax, input logic [15:0] ay,
                                                input logic [15:0] bx, input logic [15:0] by,
                                                input logic [11:0] w);
    longint unsigned dx, dy, d2, lim;
    int unsigned k;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    d2 = dx * dx + dy * dy;
    lim = longint'(w) * 64;
    lim = lim * lim;
    k = 0;
    for (int unsigned m = 256; m > 0; m--) begin
      if (longint'(m) * m * d2 <= lim) begin
        k = m;
        break;
      end
    end
    return k;
  endfunction

  function automatic segment_t predict_segment(input sample_pair_t pair);
    segment_t seg;
    int unsigned k;
    seg = '0;
    seg.point_x = scale_coord(int'(pair.left_sample), model_width);
    seg.point_y = scale_coord(-int'(pair.right_sample), model_height);
    if (model_frame_pos != 0) begin
      k = segment_scale(seg.point_x, seg.point_y, model_prev_x, model_prev_y, model_width);
      seg.line_valid   = !(seg.point_x == model_prev_x && seg.point_y == model_prev_y);
      seg.line_start_x = model_prev_x;
      seg.line_start_y = model_prev_y;
      seg.color_red    = 8'((255 * k) / 256);
      seg.color_green  = 8'(93 + (162 * k) / 256);
      seg.color_blue   = 8'(239 + (16 * k) / 256);
    end
    return seg;
  endfunction

  // Sender: one pair per transfer, random gaps unless in the quiet tail.
  always @(negedge clk_i) begin
    bit free;
    if (rst_ni) begin
      free = !in_if.valid || in_taken;
      if (in_taken) begin
        in_taken = 1'b0;
        send_gap = quiet_mode ? 0 : (($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0);
      end
      if (free) begin
        if (send_gap > 0) begin
          send_gap--;
          in_if.valid <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
          in_if.valid        <= 1'b1;
          in_if.left_sample  <= pending_pairs[0].left_sample;
          in_if.right_sample <= pending_pairs[0].right_sample;
          void'(pending_pairs.pop_front());
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    sample_pair_t pair;
    if (rst_ni && in_if.valid && in_if.ready) begin
      in_taken = 1'b1;
      pair.left_sample  = in_if.left_sample;
      pair.right_sample = in_if.right_sample;
      expected_segments.push_back(predict_segment(pair));
      model_prev_x = expected_segments[$].point_x;
      model_prev_y = expected_segments[$].point_y;
      model_frame_pos = (model_frame_pos + 1 >= FRAME_LENGTH) ? 0 : model_frame_pos + 1;
    end
  end

  // Receiver stalls.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (recv_stall > 0) begin
        recv_stall--;
        out_if.ready <= 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
        recv_stall = $urandom_range(0, 3);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    segment_t got, want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = {out_if.point_x, out_if.point_y, out_if.line_valid, out_if.line_start_x,
             out_if.line_start_y, out_if.color_red, out_if.color_green, out_if.color_blue};
      if (expected_segments.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        error_count++;
      end else begin
        want = expected_segments.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected x=%h y=%h v=%b sx=%h sy=%h rgb=%h %h %h",
                   $time, want.point_x, want.point_y, want.line_valid, want.line_start_x,
                   want.line_start_y, want.color_red, want.color_green, want.color_blue);
          $display("%0t:          actual   x=%h y=%h v=%b sx=%h sy=%h rgb=%h %h %h",
                   $time, got.point_x, got.point_y, got.line_valid, got.line_start_x,
                   got.line_start_y, got.color_red, got.color_green, got.color_blue);
          error_count++;
        end
      end
    end
  end

  task automatic write_register(input logic idx, input logic [11:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {20'd0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == REG_WIDTH) begin
      model_width = value;
    end else begin
      model_height = value;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain_block();
    while (pending_pairs.size() > 0 || in_if.valid || expected_segments.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (100) @(posedge clk_i);
  endtask

  task automatic queue_pair(input int signed l, input int signed r);
    sample_pair_t pair;
    pair.left_sample  = 16'(l);
    pair.right_sample = 16'(r);
    pending_pairs.push_back(pair);
  endtask

  function automatic int signed random_sample();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32767 : -32768;
      1: return int'($urandom_range(0, 64)) - 32768;
      2: return int'($urandom_range(0, 200)) - 100;
      default: return int'($signed(16'($urandom())));
    endcase
  endfunction

  // A wandering trace: small steps give short segments and bright colors.
  task automatic queue_random_run(input int unsigned count);
    int signed l, r;
    l = random_sample();
    r = random_sample();
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        l = random_sample();
        r = random_sample();
      end else if ($urandom_range(0, 7) == 0) begin
        // Same pair again, giving equal points.
      end else begin
        l = l + int'($urandom_range(0, 400)) - 200;
        r = r + int'($urandom_range(0, 400)) - 200;
        l = (l > 32767) ? 32767 : (l < -32768) ? -32768 : l;
        r = (r > 32767) ? 32767 : (r < -32768) ? -32768 : r;
      end
      queue_pair(l, r);
    end
  endtask

  initial begin
    error_count     = 0;
    quiet_mode      = 1'b0;
    in_taken        = 1'b0;
    send_gap        = 0;
    recv_stall      = 0;
    model_width     = WIDTH_RESET;
    model_height    = HEIGHT_RESET;
    model_prev_x    = '0;
    model_prev_y    = '0;
    model_frame_pos = 0;
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_if.valid        = 1'b0;
    in_if.left_sample  = '0;
    in_if.right_sample = '0;
    out_if.ready       = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, equal points, most negative right sample, reset sizes.
    queue_pair(-32768, -32768);
    queue_pair(32767, 32767);
    queue_pair(32767, 32767);
    queue_pair(0, 0);
    queue_pair(-32767, -32767);
    queue_pair(-32768, 32767);
    queue_pair(1, -1);
    queue_pair(16'h5555, 16'hAAAA);
    queue_pair(-21846, 21845);
    queue_pair(0, 0);
    queue_pair(1, 0);
    drain_block();

    write_register(REG_WIDTH, 12'd4095);
    write_register(REG_HEIGHT, 12'd4095);
    queue_pair(-32768, 32767);
    queue_pair(32767, -32768);
    queue_pair(32766, -32767);
    queue_pair(0, 0);
    drain_block();

    // Zero and unit sizes: zero width forces scale 0 on any real segment.
    write_register(REG_WIDTH, 12'd0);
    write_register(REG_HEIGHT, 12'd1);
    queue_pair(-32768, 0);
    queue_pair(32767, 32767);
    queue_pair(100, -32768);
    queue_pair(100, -32768);
    drain_block();
    write_register(REG_WIDTH, 12'd1);
    write_register(REG_HEIGHT, 12'd0);
    queue_pair(0, 0);
    queue_pair(32767, 1);
    queue_pair(5, 5);
    drain_block();

    // Random phases with several settings.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_register(REG_WIDTH, 12'd640);
          write_register(REG_HEIGHT, 12'd480);
        end
        1: begin
          write_register(REG_WIDTH, 12'd4095);
          write_register(REG_HEIGHT, 12'd1);
        end
        5: begin
          write_register(REG_WIDTH, 12'd640);
          write_register(REG_HEIGHT, 12'd640);
        end
        default: begin
          write_register(REG_WIDTH, 12'($urandom_range(1, 4095)));
          write_register(REG_HEIGHT, 12'($urandom_range(1, 4095)));
        end
      endcase
      quiet_mode = (phase == 5);
      queue_random_run((phase == 0) ? 520 : 90);
      if (phase == 0) begin
        queue_random_run(80);
      end
      drain_block();
    end

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
